// ===== rtl/ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants for the pixel tone mapper
// Mode codes, register map and the fixed-point sepia coefficients.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned LANES   = 3;
	localparam int unsigned PIXEL_W = CHAN_W * LANES;

	// register map, byte addressed: paddr[2] selects the register
	localparam int unsigned ADDR_W   = 3;
	localparam logic        REG_MODE   = 1'b0;
	localparam logic        REG_AMOUNT = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDENT     = 3'd0,
		MODE_BRIGHTEN  = 3'd1,
		MODE_DARKEN    = 3'd2,
		MODE_CONT_UP   = 3'd3,
		MODE_CONT_DOWN = 3'd4,
		MODE_INVERT    = 3'd5,
		MODE_SEPIA     = 3'd6,
		MODE_SPARE     = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [CHAN_W-1:0] amount;
	} cfg_t;

	// floor(v*N/1000) == (v*ceil(N*2^18/1000)) >> 18 exactly for v in 0..255
	localparam int unsigned SEPIA_SHIFT  = 18;
	localparam int unsigned COEF_W       = 19;
	localparam int unsigned PROD_W       = COEF_W + CHAN_W;
	localparam logic [COEF_W-1:0] SEPIA_COEF_R = 19'd354157;
	localparam logic [COEF_W-1:0] SEPIA_COEF_G = 19'd315360;
	localparam logic [COEF_W-1:0] SEPIA_COEF_B = 19'd245629;

endpackage

// ===== rtl/ptm_regs.sv =====
// ----------------------------------------------------------------------------
// ptm_regs: configuration registers
// APB-style slave holding the mode and amount registers.
// ----------------------------------------------------------------------------
module ptm_regs import ptm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic  wr_en;
	mode_t mode_q;
	logic [CHAN_W-1:0] amount_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDENT;
			amount_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == REG_MODE)
				mode_q <= mode_t'(pwdata[2:0]);
			else
				amount_q <= pwdata[CHAN_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_AMOUNT)
			prdata = {24'd0, amount_q};
		else
			prdata = {29'd0, mode_q};
	end

	assign cfg.mode   = mode_q;
	assign cfg.amount = amount_q;

endmodule

// ===== rtl/ptm_lane.sv =====
// ----------------------------------------------------------------------------
// ptm_lane: one channel of the point operation
// Stage 1 registers the direct result (add/sub, contrast, invert or pass-through)
// and the sepia product; the saturate/select after it feeds the output register.
// ----------------------------------------------------------------------------
module ptm_lane import ptm_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  cfg_t              cfg,
	input  logic [COEF_W-1:0] coef,
	input  logic [CHAN_W-1:0] chan_in,
	output logic [CHAN_W-1:0] chan_out
);

	logic [CHAN_W:0]   sum;
	logic [CHAN_W:0]   diff;
	logic [CHAN_W-1:0] bright;
	logic [CHAN_W-1:0] dark;
	logic [CHAN_W-1:0] direct;
	logic [CHAN_W-1:0] direct_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              sepia_s1;
	logic [PROD_W-SEPIA_SHIFT-1:0] quot;

	assign sum    = {1'b0, chan_in} + {1'b0, cfg.amount};
	assign diff   = {1'b0, chan_in} - {1'b0, cfg.amount};
	assign bright = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
	assign dark   = diff[CHAN_W] ? '0 : diff[CHAN_W-1:0];

	always_comb begin
		case (cfg.mode)
			MODE_BRIGHTEN: direct = bright;
			MODE_DARKEN:   direct = dark;
			MODE_CONT_UP:  direct = chan_in[CHAN_W-1] ? bright : dark;
			MODE_CONT_DOWN: begin
				// lower half clamps at 127, upper half at 128
				if (!chan_in[CHAN_W-1])
					direct = (sum[CHAN_W] | sum[CHAN_W-1]) ? 8'd127 : sum[CHAN_W-1:0];
				else
					direct = (diff[CHAN_W] | ~diff[CHAN_W-1]) ? 8'd128 : diff[CHAN_W-1:0];
			end
			MODE_INVERT:   direct = ~chan_in;
			default:       direct = chan_in;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			direct_s1 <= direct;
			prod_s1   <= PROD_W'(chan_in) * PROD_W'(coef);
			sepia_s1  <= (cfg.mode == MODE_SEPIA);
		end
	end

	assign quot     = prod_s1[PROD_W-1:SEPIA_SHIFT];
	assign chan_out = !sepia_s1 ? direct_s1 :
	                  quot[PROD_W-SEPIA_SHIFT-1] ? '1 : quot[CHAN_W-1:0];

endmodule

// ===== rtl/ptm_merge.sv =====
// ----------------------------------------------------------------------------
// ptm_merge: output stage
// Packs the three lane results into the output register and runs the
// master-side handshake; tells the lanes when stage 1 may advance.
// ----------------------------------------------------------------------------
module ptm_merge import ptm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic [CHAN_W-1:0]  red,
	input  logic [CHAN_W-1:0]  green,
	input  logic [CHAN_W-1:0]  blue,
	output logic               adv,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [PIXEL_W-1:0] m_tdata
);

	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_data_q;

	assign adv = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			out_data_q <= {blue, green, red};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/pixel_tone_mapper.sv =====
// ----------------------------------------------------------------------------
// pixel_tone_mapper: per-pixel RGB point operation
// Channel | Dir | Beat contents
// s_axis  | in  | tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
// m_axis  | out | tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
// apb     | in  | mode @0x0, amount @0x4
//
// One pixel per clock while the output is not stalled; registered in the lane stage, then the output register.
// The per-lane constant multiply sets the stage-1 path.
// Reset clears the valid bits and the registers (mode identity, amount 0).
// A stalled output holds its beat; stage 1 still fills behind it.
// ----------------------------------------------------------------------------
module pixel_tone_mapper import ptm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PIXEL_W-1:0] s_tdata,   // red_in, green_in, blue_in
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [PIXEL_W-1:0] m_tdata,   // red_out, green_out, blue_out
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg;
	logic adv;
	logic en_s1;
	logic valid_s1;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;

	ptm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready = !valid_s1 || adv;
	assign en_s1    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	ptm_lane u_lane_r (
		.clk      (clk),
		.en       (en_s1),
		.cfg      (cfg),
		.coef     (SEPIA_COEF_R),
		.chan_in  (s_tdata[CHAN_W-1:0]),
		.chan_out (red_out)
	);

	ptm_lane u_lane_g (
		.clk      (clk),
		.en       (en_s1),
		.cfg      (cfg),
		.coef     (SEPIA_COEF_G),
		.chan_in  (s_tdata[2*CHAN_W-1:CHAN_W]),
		.chan_out (green_out)
	);

	ptm_lane u_lane_b (
		.clk      (clk),
		.en       (en_s1),
		.cfg      (cfg),
		.coef     (SEPIA_COEF_B),
		.chan_in  (s_tdata[3*CHAN_W-1:2*CHAN_W]),
		.chan_out (blue_out)
	);

	ptm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.red      (red_out),
		.green    (green_out),
		.blue     (blue_out),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// input only backs up when both stages hold a beat and the output stalls
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("s_tready low without a full, stalled pipe");

	// a beat leaving stage 1 lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> m_tvalid)
		else $error("stage 1 beat lost");

	// a new output beat only comes from stage 1
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("output beat without a stage 1 source");

	// a mode write shows up in the register next cycle
	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_MODE) |=>
		(cfg.mode == mode_t'($past(pwdata[2:0]))))
		else $error("mode write not taken");

endmodule
